// ----- sv/fit_policy_segment_allocator_unit_assert.svh -----
// Assertion macros for the fit-policy segment allocator.
// Used by the checker module; depends on nothing else.
`ifndef FIT_POLICY_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_POLICY_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define FPSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define FPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/fpsa_pkg.sv -----
// Shared types and constants of the fit-policy segment allocator.
// No dependencies.
`timescale 1ns / 1ps

package fpsa_pkg;

  localparam int NUM_SEGMENTS_DEF = 16;
  localparam int SIZE_BITS_DEF    = 16;

  localparam int IDX_FIELD_W  = 4;
  localparam int SIZE_FIELD_W = 16;
  localparam int PID_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int COUNT_REG_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS_IN_USE = 2'd1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [COUNT_REG_W-1:0] SEGMENTS_IN_USE_RST = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

endpackage

// ----- sv/fpsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fpsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fit_policy_segment_allocator_unit.sv -----
// Top level of the fit-policy segment allocator: sequencer, config registers, result register.
// Depends on fpsa_pkg and fpsa_ram.
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------------
// in      | in_valid / in_stall  | opcode, segment_index, request_size, process_id
// out     | out_valid / out_stall| process_id_out, granted, chosen_segment,
//         |                      | remaining_after
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A load item fills the result register at acceptance. An allocate item scans the
// first N segments, where N is the effective segment count: the scan reads one
// segment per cycle through the single read port of the segment RAM.
// One item is worked on at a time; the next item is taken once the result
// has moved into the output register, so a stalled output holds back one further item.
// Reset (rst, synchronous) clears the per-segment valid bits, so every segment
// reads as zero space until loaded; no clearing pass is needed.

module fit_policy_segment_allocator_unit
  import fpsa_pkg::*;
#(
  parameter int NUM_SEGMENTS = NUM_SEGMENTS_DEF,
  parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic [IDX_FIELD_W-1:0]  segment_index,
  input  logic [SIZE_FIELD_W-1:0] request_size,
  input  logic [PID_W-1:0]        process_id,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PID_W-1:0]        process_id_out,
  output logic                    granted,
  output logic [IDX_FIELD_W-1:0]  chosen_segment,
  output logic [SIZE_FIELD_W-1:0] remaining_after,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int SEG_W  = $clog2(NUM_SEGMENTS);
  localparam int CNT_RAW = $clog2(NUM_SEGMENTS + 1);
  // The count must hold both the 5-bit register value and NUM_SEGMENTS itself.
  localparam int CNT_W  = (CNT_RAW > COUNT_REG_W) ? CNT_RAW : COUNT_REG_W;

  // Configuration registers. Writes are always taken.
  logic [1:0]             fit_mode;
  logic [COUNT_REG_W-1:0] segments_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode        <= FIT_FIRST;
      segments_in_use <= SEGMENTS_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FIT_MODE) begin
        fit_mode <= cfg_data[1:0];
      end else if (cfg_index == CFG_SEGMENTS_IN_USE) begin
        segments_in_use <= cfg_data[COUNT_REG_W-1:0];
      end
    end
  end

  // Segment count saturated to the number of segments built.
  logic [CNT_W-1:0] eff_count;
  assign eff_count = (32'(segments_in_use) > 32'(NUM_SEGMENTS)) ? CNT_W'(NUM_SEGMENTS)
                                                                : CNT_W'(segments_in_use);

  // Request size masked to SIZE_BITS (zero-extended when SIZE_BITS is wider).
  logic [SIZE_BITS+SIZE_FIELD_W-1:0] size_ext;
  logic [SIZE_BITS-1:0]              size_in;
  assign size_ext = {{SIZE_BITS{1'b0}}, request_size};
  assign size_in  = size_ext[SIZE_BITS-1:0];

  // Load index checked against the effective count before it is narrowed.
  logic [IDX_FIELD_W+CNT_W-1:0] load_idx_ext;
  logic                         load_ok;
  assign load_idx_ext = {{CNT_W{1'b0}}, segment_index};
  assign load_ok      = load_idx_ext < (IDX_FIELD_W+CNT_W)'(eff_count);

  // Segment RAM plus a valid bit per segment; an unwritten segment reads as zero.
  logic                 ram_we;
  logic [SEG_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SEG_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic [NUM_SEGMENTS-1:0] seg_vld;
  logic                 rd_vld;

  fpsa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer state.
  state_t state, state_next;

  logic                 accept;
  logic                 out_free;
  logic [SIZE_BITS-1:0] need;
  logic [PID_W-1:0]     pid_q;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 issue_go;
  logic                 pipe_v;
  logic [SEG_W-1:0]     pipe_idx;
  logic                 found;
  logic [SEG_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_rem;
  logic [SIZE_BITS-1:0] cur_rem;
  logic                 take;
  logic [SIZE_BITS-1:0] new_rem;
  logic                 res_granted;
  logic [SEG_W-1:0]     res_seg;
  logic [SIZE_BITS-1:0] res_rem;
  logic [SEG_W+IDX_FIELD_W-1:0]     res_seg_ext;
  logic [SIZE_BITS+SIZE_FIELD_W-1:0] res_rem_ext;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign issue_go  = (state == ST_SCAN) && (issue_cnt < eff_count);
  assign ram_raddr = issue_cnt[SEG_W-1:0];

  // A candidate fits when its space covers the request. First fit keeps the
  // first hit; best and worst fit replace only on a strictly better value, so
  // ties stay at the lowest index.
  assign cur_rem = rd_vld ? ram_rdata : '0;
  assign take = pipe_v && (cur_rem >= need) &&
                (!found ||
                 ((fit_mode == FIT_BEST)  && (cur_rem < best_rem)) ||
                 ((fit_mode == FIT_WORST) && (cur_rem > best_rem)));

  assign new_rem = best_rem - need;

  // The single write port serves loads at acceptance and allocations at commit.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = new_rem;
    if (accept && (opcode == OP_LOAD) && load_ok) begin
      ram_we    = 1'b1;
      ram_waddr = load_idx_ext[SEG_W-1:0];
      ram_wdata = size_in;
    end else if ((state == ST_COMMIT) && found) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (opcode == OP_LOAD) ? ST_REPORT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue_go && !pipe_v) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: state_next = ST_REPORT;
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_vld   <= '0;
      pipe_v    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      issue_cnt <= '0;
    end else begin
      state  <= state_next;
      pipe_v <= issue_go;
      if (ram_we) begin
        seg_vld[ram_waddr] <= 1'b1;
      end
      if (accept) begin
        issue_cnt <= '0;
        found     <= 1'b0;
      end else begin
        if (issue_go) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
        end
        if (take) begin
          found <= 1'b1;
        end
      end
      if ((state == ST_REPORT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_vld   <= seg_vld[ram_raddr];
    pipe_idx <= ram_raddr;
    if (accept) begin
      need        <= size_in;
      pid_q       <= process_id;
      res_granted <= load_ok;
      res_seg     <= load_ok ? load_idx_ext[SEG_W-1:0] : '0;
      res_rem     <= load_ok ? size_in : '0;
    end
    if (take) begin
      best_idx <= pipe_idx;
      best_rem <= cur_rem;
    end
    if (state == ST_COMMIT) begin
      res_granted <= found;
      res_seg     <= found ? best_idx : '0;
      res_rem     <= found ? new_rem : '0;
    end
    if ((state == ST_REPORT) && out_free) begin
      process_id_out  <= pid_q;
      granted         <= res_granted;
      chosen_segment  <= res_seg_ext[IDX_FIELD_W-1:0];
      remaining_after <= res_rem_ext[SIZE_FIELD_W-1:0];
    end
  end

  assign res_seg_ext = {{IDX_FIELD_W{1'b0}}, res_seg};
  assign res_rem_ext = {{SIZE_FIELD_W{1'b0}}, res_rem};

endmodule

// ----- sv/fpsa_checker.sv -----
// Port-level checker for the fit-policy segment allocator, bound to the top level.
// Depends on fpsa_pkg and fit_policy_segment_allocator_unit_assert.svh.
`timescale 1ns / 1ps
`include "fit_policy_segment_allocator_unit_assert.svh"

module fpsa_checker
  import fpsa_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    granted,
  input logic [IDX_FIELD_W-1:0]  chosen_segment,
  input logic [SIZE_FIELD_W-1:0] remaining_after
);

  `FPSA_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "stalled result dropped")
  `FPSA_ASSERT_NOW(a_fail_zero, out_valid && !granted, (chosen_segment == '0) && (remaining_after == '0), "failed result carries nonzero fields")
  `FPSA_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second item taken while one is in work")
  `FPSA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(granted) && $stable(chosen_segment) && $stable(remaining_after), "stalled result changed")

endmodule

bind fit_policy_segment_allocator_unit fpsa_checker u_fpsa_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .granted         (granted),
  .chosen_segment  (chosen_segment),
  .remaining_after (remaining_after)
);

// ----- tb/fit_policy_segment_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fit_policy_segment_allocator_unit: load and allocate items,
// register writes, and a local model of the segment table that predicts every result.
// Depends on fpsa_pkg and the allocator RTL.

module fit_policy_segment_allocator_unit_tb;
  import fpsa_pkg::*;

  localparam int SEGMENTS        = NUM_SEGMENTS_DEF;
  localparam int CYCLE_LIMIT     = 1_000_000;
  // An allocation scans every segment in use; the settle time is sized from the segment count to cover the tail.
  localparam int SETTLE_CYCLES   = 2 * SEGMENTS + 8;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int MAX_REPORTS     = 10;

  // Fit mode 3 has no name in the package; the block treats it as first fit.
  localparam logic [1:0] FIT_UNUSED = 2'd3;
  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_HI = 2'd3;

  typedef struct packed {
    logic                    op;
    logic [IDX_FIELD_W-1:0]  index;
    logic [SIZE_FIELD_W-1:0] size;
    logic [PID_W-1:0]        pid;
  } segment_request_t;

  typedef struct packed {
    logic [PID_W-1:0]        pid;
    logic                    granted;
    logic [IDX_FIELD_W-1:0]  segment;
    logic [SIZE_FIELD_W-1:0] remaining;
  } grant_t;

  // Every input starts at a known value; the stimulus drives them on falling edges.
  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic                    opcode         = OP_LOAD;
  logic [IDX_FIELD_W-1:0]  segment_index  = '0;
  logic [SIZE_FIELD_W-1:0] request_size   = '0;
  logic [PID_W-1:0]        process_id     = '0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic [PID_W-1:0]        process_id_out;
  logic                    granted;
  logic [IDX_FIELD_W-1:0]  chosen_segment;
  logic [SIZE_FIELD_W-1:0] remaining_after;
  logic                    cfg_valid      = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data       = '0;

  // Local copy of the segment table and of the two registers.
  logic [SIZE_FIELD_W-1:0] space_left [SEGMENTS];
  logic [1:0]              fit_mode_q;
  logic [COUNT_REG_W-1:0]  segments_in_use_q;

  // Results predicted for accepted items, oldest first.
  grant_t pending_grants [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  // Percent chance of a sender gap before an item, and of a receiver stall per cycle.
  int gap_pct        = 0;
  int stall_pct      = 0;

  fit_policy_segment_allocator_unit uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .segment_index   (segment_index),
    .request_size    (request_size),
    .process_id      (process_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .process_id_out  (process_id_out),
    .granted         (granted),
    .chosen_segment  (chosen_segment),
    .remaining_after (remaining_after),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective segment count: the register saturates at the table size.
  function automatic int active_segments();
    return (segments_in_use_q > SEGMENTS) ? SEGMENTS : int'(segments_in_use_q);
  endfunction

  // Applies one item to the local table and returns the result the block must give.
  // Ties in best and worst fit keep the lower index because only a strict improvement
  // replaces the current pick; first fit (and the unused mode) keeps the first hit.
  function automatic grant_t apply_request(input segment_request_t req);
    grant_t res;
    int     active;
    int     pick;
    res     = '0;
    res.pid = req.pid;
    active  = active_segments();
    if (req.op == OP_LOAD) begin
      if (int'(req.index) < active) begin
        space_left[req.index] = req.size;
        res.granted   = 1'b1;
        res.segment   = req.index;
        res.remaining = req.size;
      end
    end else begin
      pick = -1;
      for (int i = 0; i < active; i++) begin
        if (space_left[i] >= req.size) begin
          if (pick < 0) begin
            pick = i;
          end else if (fit_mode_q == FIT_BEST && space_left[i] < space_left[pick]) begin
            pick = i;
          end else if (fit_mode_q == FIT_WORST && space_left[i] > space_left[pick]) begin
            pick = i;
          end
        end
      end
      if (pick >= 0) begin
        space_left[pick] = space_left[pick] - req.size;
        res.granted   = 1'b1;
        res.segment   = pick[IDX_FIELD_W-1:0];
        res.remaining = space_left[pick];
      end
    end
    return res;
  endfunction

  // Sender side. An optional gap comes first, so gaps land on every phase of an
  // allocation. The item is accepted at a rising edge with in_stall low, and its
  // result is predicted at that moment.
  task automatic send_item(input segment_request_t req);
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2 * SEGMENTS)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= req.op;
    segment_index <= req.index;
    request_size  <= req.size;
    process_id    <= req.pid;
    do @(posedge clk); while (in_stall);
    pending_grants.push_back(apply_request(req));
  endtask

  // Holds the sender off until every predicted result has come out. Each item gives
  // exactly one result, so an empty queue means the block is idle.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle; the local copy follows the
  // write once the handshake completes. Unknown indexes change nothing.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_for_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FIT_MODE:        fit_mode_q = data[1:0];
      CFG_SEGMENTS_IN_USE: segments_in_use_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_segment(input logic [IDX_FIELD_W-1:0] idx,
                              input logic [SIZE_FIELD_W-1:0] size,
                              input logic [PID_W-1:0] pid);
    send_item('{op: OP_LOAD, index: idx, size: size, pid: pid});
  endtask

  // The segment index of an allocate item is ignored, so it carries noise.
  task automatic request_space(input logic [SIZE_FIELD_W-1:0] size,
                               input logic [PID_W-1:0] pid);
    send_item('{op: OP_ALLOC, index: IDX_FIELD_W'($urandom), size: size, pid: pid});
  endtask

  // Random item shaped by the current table: most allocations ask for an exact fit or
  // for less than some segment holds, the rest are zero or any size at all. Loads
  // mostly target segments in use and favor small sizes so that ties are common.
  function automatic segment_request_t random_request();
    segment_request_t req;
    int               active;
    int               target;
    int               roll;
    active    = active_segments();
    req.pid   = PID_W'($urandom);
    req.index = IDX_FIELD_W'($urandom);
    roll      = $urandom_range(0, 99);
    if (roll < 30) begin
      req.op = OP_LOAD;
      if (active > 0 && $urandom_range(0, 99) < 80) begin
        req.index = IDX_FIELD_W'($urandom_range(0, active - 1));
      end
      case ($urandom_range(0, 4))
        0, 1:    req.size = SIZE_FIELD_W'($urandom_range(0, 64));
        2:       req.size = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        default: req.size = SIZE_FIELD_W'($urandom);
      endcase
    end else begin
      req.op = OP_ALLOC;
      target = (active > 0) ? $urandom_range(0, active - 1) : 0;
      roll   = $urandom_range(0, 99);
      if (roll < 25) begin
        req.size = space_left[target];
      end else if (roll < 60) begin
        req.size = SIZE_FIELD_W'($urandom_range(0, space_left[target]));
      end else if (roll < 70) begin
        req.size = '0;
      end else begin
        req.size = SIZE_FIELD_W'($urandom);
      end
    end
    return req;
  endfunction

  // After reset every segment is empty: a zero-size request still fits segment 0,
  // anything larger fits nowhere.
  task automatic test_empty_segments();
    request_space(16'd0, 8'h00);
    request_space(16'd1, 8'hFF);
  endtask

  // Full-scale sizes on the first and last segment, then segment 0 emptied again.
  task automatic test_load_extremes();
    load_segment(4'd15, 16'hFFFF, 8'hAA);
    load_segment(4'd0, 16'hFFFF, 8'h55);
    request_space(16'hFFFF, 8'h01);
    load_segment(4'd0, 16'h0000, 8'h02);
  endtask

  // First fit takes the lowest index that fits; the last request is an exact fit,
  // which must be accepted since a segment fits when its space equals the request.
  task automatic test_first_fit();
    write_register(CFG_FIT_MODE, CFG_DATA_W'(FIT_FIRST));
    load_segment(4'd1, 16'd100, 8'h10);
    load_segment(4'd2, 16'd300, 8'h11);
    load_segment(4'd3, 16'd50, 8'h12);
    request_space(16'd80, 8'h13);
    request_space(16'd200, 8'h14);
    request_space(16'd20, 8'h15);
  endtask

  // Segments 3 and 4 both hold 50: the tie must go to segment 3.
  task automatic test_best_fit();
    write_register(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
    load_segment(4'd4, 16'd50, 8'h20);
    request_space(16'd40, 8'h21);
    request_space(16'd60, 8'h22);
  endtask

  // Worst fit goes to the largest segment; with 14 and 15 equal, 14 wins.
  task automatic test_worst_fit();
    write_register(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
    request_space(16'd1, 8'h30);
    load_segment(4'd14, 16'd65534, 8'h31);
    request_space(16'd2, 8'h32);
  endtask

  // The unused mode value behaves as first fit; the upper data bits are dropped.
  task automatic test_unused_fit_mode();
    write_register(CFG_FIT_MODE, {3'b111, FIT_UNUSED});
    request_space(16'd5, 8'h40);
  endtask

  // Segment count zero refuses everything, counts above the table size saturate,
  // and a load past the count is refused without touching the table.
  task automatic test_segment_count();
    write_register(CFG_SEGMENTS_IN_USE, 5'd0);
    load_segment(4'd0, 16'd9, 8'h50);
    request_space(16'd0, 8'h51);
    write_register(CFG_SEGMENTS_IN_USE, 5'd31);
    request_space(16'd0, 8'h52);
    write_register(CFG_SEGMENTS_IN_USE, 5'd1);
    load_segment(4'd1, 16'd7, 8'h53);
    request_space(16'd1, 8'h54);
    write_register(CFG_SEGMENTS_IN_USE, 5'd17);
  endtask

  // Writes to indexes with no register must leave mode and count alone; a request
  // that only a segment past index 1 can serve shows the count is still full.
  task automatic test_unknown_register();
    write_register(CFG_UNKNOWN_LO, 5'd0);
    write_register(CFG_UNKNOWN_HI, 5'b00001);
    request_space(16'd3, 8'h60);
  endtask

  // Random items in phases, each with its own register settings and idle pattern:
  // none, sender gaps, receiver stalls, then both lightly. Midway through one phase
  // the sender holds off until every outstanding result has come out.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] count_sel;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 52; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      // Full random data word: the mode lands on all four values and the upper
      // bits, which the register drops, see both levels.
      write_register(CFG_FIT_MODE, CFG_DATA_W'($urandom));
      case ($urandom_range(0, 7))
        0:       count_sel = 5'd1;
        1:       count_sel = 5'd2;
        2:       count_sel = CFG_DATA_W'($urandom_range(3, 15));
        3:       count_sel = CFG_DATA_W'($urandom_range(17, 31));
        default: count_sel = 5'd16;
      endcase
      write_register(CFG_SEGMENTS_IN_USE, count_sel);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
          wait_for_drain();
        end
        send_item(random_request());
      end
    end
  endtask

  // Receiver side: the stall is redrawn every cycle at the current rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Every result taken at a rising edge is matched against the oldest prediction,
  // field by field. Only the first few problems are printed.
  always @(posedge clk) begin
    grant_t seen;
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = {process_id_out, granted, chosen_segment, remaining_after};
      if (pending_grants.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result pid %0d granted %0d segment %0d remaining %0d",
                   $realtime, seen.pid, seen.granted, seen.segment, seen.remaining);
        end
      end else begin
        want = pending_grants.pop_front();
        if (seen.pid !== want.pid || seen.granted !== want.granted ||
            seen.segment !== want.segment || seen.remaining !== want.remaining) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch expected pid %0d granted %0d segment %0d remaining %0d",
                     $realtime, want.pid, want.granted, want.segment, want.remaining);
            $display("%0t:          actual   pid %0d granted %0d segment %0d remaining %0d",
                     $realtime, seen.pid, seen.granted, seen.segment, seen.remaining);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL fit_policy_segment_allocator_unit");
    $finish;
  end

  initial begin
    // Local table and registers start at their reset values.
    for (int i = 0; i < SEGMENTS; i++) begin
      space_left[i] = '0;
    end
    fit_mode_q        = FIT_FIRST;
    segments_in_use_q = SEGMENTS_IN_USE_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_segments();
    test_load_extremes();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_unused_fit_mode();
    test_segment_count();
    test_unknown_register();
    test_random_traffic();

    // Let everything outstanding come out, then watch a little longer for strays.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS fit_policy_segment_allocator_unit");
    end else begin
      $display("FAIL fit_policy_segment_allocator_unit");
    end
    $finish;
  end

endmodule
